### sv/pmm_pkg.sv
package pmm_pkg;

   typedef enum logic [1:0] {
      OP_MEM_RD = 2'd0,
      OP_MEM_WR = 2'd1,
      OP_IO_RD  = 2'd2,
      OP_IO_WR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RGN_RAM    = 3'd0,
      RGN_VRAM   = 3'd1,
      RGN_BACKUP = 3'd2,
      RGN_BOOT   = 3'd3,
      RGN_FONT   = 3'd4,
      RGN_EXP    = 3'd5,
      RGN_NONE   = 3'd6
   } region_type;

   typedef enum logic [1:0] {
      PC_NONE,
      PC_PAGE,
      PC_SELECT
   } pclass_type;

   localparam logic [15:0] PORT_INDEX = 16'h00ee;
   localparam logic [15:0] PORT_DATA  = 16'h00ef;
   localparam logic [7:0]  IDX_FRAME  = 8'd50;
   localparam logic [7:0]  IDX_CONFIG = 8'd51;
   localparam logic [7:0]  RD_UNMAPPED = 8'hff;

   typedef struct packed {
      op_type      op;
      logic [19:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      region_type  region;
      logic [19:0] offset;
      logic        write_enable;
      logic [7:0]  io_read_data;
   } rsp_type;

   typedef struct packed {
      logic [7:0]      index;
      logic [3:0]      frame_sel;
      logic [4:0]      config_bits;
      logic [3:0][7:0] page;
      logic [3:0]      window_sel;
      logic [4:0]      font_bank;
   } state_type;

   // Page and window-select ports sit at one of seven bases, chosen by the
   // frame select nibble; bits 15..14 of the port pick the page.
   function automatic pclass_type port_class(input logic [15:0] port,
                                             input logic [3:0] frame_sel);
      logic [3:0] mid;
      logic       base;
      mid  = port[7:4];
      base = mid inside {4'h0, 4'h1, 4'h5, 4'h6, 4'ha, 4'hb, 4'he};
      if (port[13:8] != 6'h02 || port[3:1] != 3'b100 || !base || mid != frame_sel) begin
         return PC_NONE;
      end
      return port[0] ? PC_SELECT : PC_PAGE;
   endfunction

endpackage

### sv/pmm_channels.sv
interface pmm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [19:0] address;
   logic [7:0]  write_data;

   modport source (output valid, opcode, address, write_data, input ready);
   modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

interface pmm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  target_region;
   logic [19:0] target_offset;
   logic        write_enable;
   logic [7:0]  io_read_data;

   modport source (output valid, target_region, target_offset, write_enable, io_read_data,
                   input ready);
   modport sink   (input valid, target_region, target_offset, write_enable, io_read_data,
                   output ready);
endinterface

### sv/pmm_regs.sv
module pmm_regs
   import pmm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      apply,
   input  req_type   req,
   output state_type state
);

   state_type  state_ff, state_in;
   logic [15:0] port;
   logic [1:0]  sel;
   pclass_type  cls;

   assign port = req.address[15:0];
   assign sel  = port[15:14];
   assign cls  = port_class(port, state_ff.frame_sel);

   always_comb begin
      state_in = state_ff;
      if (apply) begin
         case (req.op)
            OP_MEM_WR: begin
               // E-segment write selects the font bank
               if (req.address[19:16] == 4'he) begin
                  state_in.font_bank = {req.write_data[7], req.write_data[3:0]};
               end
            end
            OP_IO_WR: begin
               if (port == PORT_INDEX) begin
                  state_in.index = req.write_data;
               end else if (port == PORT_DATA) begin
                  if (state_ff.index == IDX_FRAME) begin
                     state_in.frame_sel = req.write_data[3:0];
                  end else if (state_ff.index == IDX_CONFIG) begin
                     state_in.config_bits = req.write_data[4:0];
                  end
               end else if (cls == PC_PAGE) begin
                  state_in.page[sel] = req.write_data;
               end else if (cls == PC_SELECT) begin
                  state_in.window_sel[sel] = req.write_data[7];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.index       <= '0;
         state_ff.frame_sel   <= '0;
         state_ff.config_bits <= 5'd2;
         state_ff.page        <= '0;
         state_ff.window_sel  <= 4'd3;
         state_ff.font_bank   <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

### sv/pmm_decode.sv
module pmm_decode
   import pmm_pkg::*;
#(
   parameter int unsigned EXP_PAGES = 56
)(
   input  req_type   req,
   input  state_type state,
   output rsp_type   rsp
);

   localparam logic [7:0] EXP_LIMIT = 8'(EXP_PAGES);

   logic [19:0] a;
   logic        wr;
   logic [1:0]  slot;
   logic [3:0]  slot_ext;
   logic [7:0]  pg;
   logic        page_ok;
   logic        win_hit;
   logic [15:0] port;
   pclass_type  cls;

   assign a        = req.address;
   assign wr       = req.op == OP_MEM_WR;
   assign slot     = a[15:14];
   assign slot_ext = {2'b00, slot};
   assign pg       = state.page[slot];
   assign page_ok  = pg[7] && ({1'b0, pg[6:0]} < EXP_LIMIT);
   // Page 0 always lands in D; others move to C while the select value is below them
   assign win_hit  = (a[19:17] == 3'b110) && page_ok &&
                     (a[16] ? (slot == 2'd0 || state.window_sel >= slot_ext)
                            : (slot != 2'd0 && state.window_sel < slot_ext));
   assign port     = a[15:0];
   assign cls      = port_class(port, state.frame_sel);

   always_comb begin
      rsp.region       = RGN_NONE;
      rsp.offset       = '0;
      rsp.write_enable = 1'b0;
      rsp.io_read_data = '0;
      case (req.op)
         OP_MEM_RD, OP_MEM_WR: begin
            if (wr && a[19:16] == 4'he) begin
               // font bank select, nothing stored
            end else if (a < 20'ha0000) begin
               rsp.region = RGN_RAM;
               rsp.offset = a;
            end else if (a[19:15] == 5'b10111) begin
               rsp.region = RGN_VRAM;
               rsp.offset = {5'b0, a[14:0]};
            end else if (win_hit) begin
               rsp.region = RGN_EXP;
               rsp.offset = {pg[5:0], a[13:0]};
            end else if (a[19:16] == 4'he) begin
               if (state.font_bank[4]) begin
                  rsp.region = RGN_FONT;
                  rsp.offset = {state.font_bank[3:0], a[15:0]};
               end
            end else if (a[19:11] == 9'h1e0) begin
               rsp.region = RGN_BACKUP;
               rsp.offset = {9'b0, a[10:0]};
            end else if (a[19:15] == 5'b11111 && !wr) begin
               rsp.region = RGN_BOOT;
               rsp.offset = {5'b0, a[14:0]};
            end
            if (wr) begin
               if (rsp.region == RGN_FONT) begin
                  rsp.region = RGN_NONE;
                  rsp.offset = '0;
               end
               rsp.write_enable = rsp.region != RGN_NONE;
            end
         end
         OP_IO_RD: begin
            rsp.io_read_data = RD_UNMAPPED;
            if (port == PORT_DATA) begin
               if (state.index == IDX_FRAME) begin
                  rsp.io_read_data = {4'h8, state.frame_sel};
               end else if (state.index == IDX_CONFIG) begin
                  rsp.io_read_data = {state.window_sel[2:0], state.config_bits};
               end
            end else if (cls == PC_PAGE) begin
               rsp.io_read_data = state.page[port[15:14]];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### sv/paged_memory_mapper.sv
// Paged memory and I/O mapper for a 20-bit bus. Each request (memory read,
// memory write, I/O read, I/O write) gives exactly one response naming the
// target region and byte offset, a write enable, and I/O read data. One
// request is taken every clock unless the response side holds back ready.
// Each request waits in the input register, passes through a single decode
// pass, and is offered from the response register.
// Mapper registers (index/data pair,
// page registers, window-select bits, font bank) update in request order as
// each request leaves the input register. No clearing pass after reset.
module paged_memory_mapper
   import pmm_pkg::*;
#(
   parameter int unsigned EXP_PAGES = 56
)(
   input  logic        clock,
   input  logic        reset,
   pmm_req_if.sink     req_ch,
   pmm_rsp_if.source   rsp_ch
);

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_rsp_ff;
   rsp_type   dec_rsp;
   state_type state;
   logic      advance;
   logic      req_fire;

   // Move the held request into the response register when that slot frees up
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      // hold payloads unless a new request or decoded response lands
      if (req_fire) begin
         s1_req_ff.op         <= op_type'(req_ch.opcode);
         s1_req_ff.address    <= req_ch.address;
         s1_req_ff.write_data <= req_ch.write_data;
      end
      if (advance) begin
         out_rsp_ff <= dec_rsp;
      end
   end

   // Mapper state: decode sees the state before this request's own update
   pmm_regs u_regs (
      .clock (clock),
      .reset (reset),
      .apply (advance),
      .req   (s1_req_ff),
      .state (state)
   );

   pmm_decode #(
      .EXP_PAGES (EXP_PAGES)
   ) u_decode (
      .req   (s1_req_ff),
      .state (state),
      .rsp   (dec_rsp)
   );

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.target_region = 3'(out_rsp_ff.region);
   assign rsp_ch.target_offset = out_rsp_ff.offset;
   assign rsp_ch.write_enable  = out_rsp_ff.write_enable;
   assign rsp_ch.io_read_data  = out_rsp_ff.io_read_data;

`ifndef SYNTHESIS
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("decoded request did not reach the response register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_ch.ready)
      else $error("input register overwritten while full");

   a_we_region: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.write_enable) |->
      (out_rsp_ff.region == RGN_RAM || out_rsp_ff.region == RGN_VRAM ||
       out_rsp_ff.region == RGN_BACKUP || out_rsp_ff.region == RGN_EXP))
      else $error("write enabled into a read-only or unmapped region");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.region == RGN_NONE) |-> (out_rsp_ff.offset == '0))
      else $error("unmapped response carries an offset");

   a_io_data_only_io: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.io_read_data != '0) |->
      (out_rsp_ff.region == RGN_NONE && !out_rsp_ff.write_enable))
      else $error("I/O read data on a memory response");
`endif

endmodule
